/* sv/rtpsrb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP reorder buffer package
// Shared constants, sequencer states and inter-module control structs.
// ----------------------------------------------------------------------------
package rtpsrb_pkg;

    localparam int SLOTS       = 8;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int SEQ_W       = 16;
    localparam int HANDLE_W    = 32;
    localparam int LEN_W       = 16;
    localparam int LIMIT_W     = 4;
    localparam int CMP_W       = (LIMIT_W > CNT_W) ? LIMIT_W : CNT_W;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 48;

    localparam logic [LEN_W-1:0]   MIN_LENGTH  = LEN_W'(12);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DUP_SCAN,
        ST_INSERT,
        ST_RELEASE,
        ST_SKIP_CHECK,
        ST_NEAREST,
        ST_SKIP_APPLY,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic                insert;
        logic [IDX_W-1:0]    insert_idx;
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] handle;
        logic                clear;
        logic [IDX_W-1:0]    clear_idx;
    } slot_wr_t;

    typedef struct packed {
        logic                valid;
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] handle;
    } slot_rd_t;

    typedef struct packed {
        logic                push;
        logic [HANDLE_W-1:0] handle;
        logic [SEQ_W-1:0]    seq;
        logic                start;
        logic                gap;
    } out_ctl_t;

endpackage

/* sv/rtp_sequence_reorder_buffer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP sequence reorder buffer
// Reorders packet descriptors by RTP sequence number with a bounded window.
//
// s_axis carries one packet descriptor per transaction. Short packets and
// packets behind the expected number are dropped; others, unless duplicate
// or no slot is free, are stored in one of SLOTS pending slots. Released
// packets leave on m_axis in sequence order, tlast on the final one of each
// input, tuser set when the input forced a skip over missing numbers.
// cfg_wr_en/cfg_wr_data write window_limit. Each input is taken in, scanned
// over all slots for a duplicate and a free slot and stored; a release run
// then takes the expected number from the slots until a full pass finds
// none or the output queue is full, followed by the skip check and a finish
// step; a skip adds a scan for the nearest number, a step to apply it and a
// second run. One shared compare unit walks the slots one per cycle. Results
// drain at one transaction per cycle while m_axis_tready is high. s_axis is
// not ready while an input is in progress or its results are still draining;
// a stalled receiver holds the current result. Reset empties all slots and
// clears the start flag and the expected number; window_limit returns to 8.
// ----------------------------------------------------------------------------
module rtp_sequence_reorder_buffer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [rtpsrb_pkg::LIMIT_W-1:0]      cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // seq_number[15:0], packet_handle[47:16], packet_length[63:48]
    input  logic [rtpsrb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_handle[31:0], out_seq[47:32]
    output logic [rtpsrb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // gap_flag[0]
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);
    import rtpsrb_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] MISS_LAST = CNT_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

    seq_state_t          state_reg;
    seq_state_t          state_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic                started_reg;
    logic                started_next;
    logic [SEQ_W-1:0]    exp_reg;
    logic [SEQ_W-1:0]    exp_next;
    logic [SEQ_W-1:0]    seq_reg;
    logic [SEQ_W-1:0]    seq_next;
    logic [HANDLE_W-1:0] handle_reg;
    logic [HANDLE_W-1:0] handle_next;
    logic [IDX_W-1:0]    scan_idx_reg;
    logic [IDX_W-1:0]    scan_idx_next;
    logic [CNT_W-1:0]    miss_cnt_reg;
    logic [CNT_W-1:0]    miss_cnt_next;
    logic                dup_reg;
    logic                dup_next;
    logic                free_found_reg;
    logic                free_found_next;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [IDX_W-1:0]    free_idx_next;
    logic                best_found_reg;
    logic                best_found_next;
    logic [SEQ_W-1:0]    best_d_reg;
    logic [SEQ_W-1:0]    best_d_next;
    logic [SEQ_W-1:0]    best_seq_reg;
    logic [SEQ_W-1:0]    best_seq_next;
    logic                gap_reg;
    logic                gap_next;
    logic                phase2_reg;
    logic                phase2_next;

    logic [SEQ_W-1:0]    in_seq;
    logic [HANDLE_W-1:0] in_handle;
    logic [LEN_W-1:0]    in_len;
    logic                in_accept;
    logic                in_short;
    logic [SEQ_W-1:0]    exp_eff;

    logic                cmp_valid;
    logic [SEQ_W-1:0]    cmp_a;
    logic [SEQ_W-1:0]    cmp_base;
    logic                cmp_match;
    logic [SEQ_W-1:0]    cmp_dist;

    slot_wr_t            slot_wr;
    slot_rd_t            slot_rd;
    logic [CNT_W-1:0]    pending_count;
    out_ctl_t            out_ctl;
    logic [CNT_W-1:0]    out_count;
    logic                out_busy;

    logic [IDX_W-1:0]    scan_idx_inc;
    logic                run_full;
    logic                rel_hit;
    logic                run_done;
    logic [CMP_W-1:0]    limit_ext;
    logic [CMP_W-1:0]    limit_eff;
    logic                skip_due;

    assign in_seq    = s_axis_tdata[SEQ_W-1:0];
    assign in_handle = s_axis_tdata[SEQ_W+HANDLE_W-1:SEQ_W];
    assign in_len    = s_axis_tdata[SEQ_W+HANDLE_W+LEN_W-1:SEQ_W+HANDLE_W];

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_busy;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_short      = in_len < MIN_LENGTH;
    assign exp_eff       = started_reg ? exp_reg : in_seq;

    assign scan_idx_inc = (scan_idx_reg == IDX_LAST) ? '0 : scan_idx_reg + IDX_W'(1);
    assign run_full     = out_count == SLOTS_CNT;
    assign rel_hit      = !run_full && cmp_match;
    assign run_done     = run_full || (!cmp_match && (miss_cnt_reg == MISS_LAST));

    assign limit_ext = CMP_W'(limit_reg);
    always_comb
    begin
        if (limit_ext == '0)
        begin
            limit_eff = CMP_W'(1);
        end
        else if (limit_ext > CMP_W'(SLOTS))
        begin
            limit_eff = CMP_W'(SLOTS);
        end
        else
        begin
            limit_eff = limit_ext;
        end
    end
    assign skip_due = CMP_W'(pending_count) >= limit_eff;

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            cmp_valid = 1'b1;
            cmp_a     = in_seq;
            cmp_base  = exp_eff;
        end
        else if (state_reg == ST_DUP_SCAN)
        begin
            cmp_valid = slot_rd.valid;
            cmp_a     = slot_rd.seq;
            cmp_base  = seq_reg;
        end
        else
        begin
            cmp_valid = slot_rd.valid;
            cmp_a     = slot_rd.seq;
            cmp_base  = exp_reg;
        end
    end

    rtpsrb_cmp_unit u_cmp (
        .a_valid  (cmp_valid),
        .a_seq    (cmp_a),
        .base_seq (cmp_base),
        .match    (cmp_match),
        .seq_dist (cmp_dist)
    );

    rtpsrb_slot_store u_slots (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr            (slot_wr),
        .rd_idx        (scan_idx_reg),
        .rd            (slot_rd),
        .pending_count (pending_count)
    );

    rtpsrb_out_buffer u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (out_ctl),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .count         (out_count),
        .busy          (out_busy)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && !in_short && !cmp_dist[SEQ_W-1])
                begin
                    state_next = ST_DUP_SCAN;
                end
            end
            ST_DUP_SCAN:
            begin
                if (scan_idx_reg == IDX_LAST)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                state_next = ST_RELEASE;
            end
            ST_RELEASE:
            begin
                if (run_done)
                begin
                    state_next = phase2_reg ? ST_FINISH : ST_SKIP_CHECK;
                end
            end
            ST_SKIP_CHECK:
            begin
                state_next = skip_due ? ST_NEAREST : ST_FINISH;
            end
            ST_NEAREST:
            begin
                if (scan_idx_reg == IDX_LAST)
                begin
                    state_next = ST_SKIP_APPLY;
                end
            end
            ST_SKIP_APPLY:
            begin
                state_next = best_found_reg ? ST_RELEASE : ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        started_next    = started_reg;
        exp_next        = exp_reg;
        seq_next        = seq_reg;
        handle_next     = handle_reg;
        scan_idx_next   = scan_idx_reg;
        miss_cnt_next   = miss_cnt_reg;
        dup_next        = dup_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_found_next = best_found_reg;
        best_d_next     = best_d_reg;
        best_seq_next   = best_seq_reg;
        gap_next        = gap_reg;
        phase2_next     = phase2_reg;
        slot_wr         = '0;
        slot_wr.insert_idx = free_idx_reg;
        slot_wr.seq        = seq_reg;
        slot_wr.handle     = handle_reg;
        slot_wr.clear_idx  = scan_idx_reg;
        out_ctl         = '0;
        out_ctl.handle  = slot_rd.handle;
        out_ctl.seq     = slot_rd.seq;
        out_ctl.gap     = gap_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && !in_short)
                begin
                    started_next = 1'b1;
                    exp_next     = exp_eff;
                    if (!cmp_dist[SEQ_W-1])
                    begin
                        seq_next        = in_seq;
                        handle_next     = in_handle;
                        scan_idx_next   = '0;
                        dup_next        = 1'b0;
                        free_found_next = 1'b0;
                        phase2_next     = 1'b0;
                        gap_next        = 1'b0;
                    end
                end
            end
            ST_DUP_SCAN:
            begin
                if (cmp_match)
                begin
                    dup_next = 1'b1;
                end
                if (!slot_rd.valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = scan_idx_reg;
                end
                scan_idx_next = scan_idx_inc;
            end
            ST_INSERT:
            begin
                slot_wr.insert = !dup_reg && free_found_reg;
                scan_idx_next  = '0;
                miss_cnt_next  = '0;
            end
            ST_RELEASE:
            begin
                scan_idx_next = scan_idx_inc;
                if (rel_hit)
                begin
                    out_ctl.push  = 1'b1;
                    slot_wr.clear = 1'b1;
                    exp_next      = exp_reg + SEQ_W'(1);
                    miss_cnt_next = '0;
                end
                else
                begin
                    miss_cnt_next = miss_cnt_reg + CNT_W'(1);
                end
            end
            ST_SKIP_CHECK:
            begin
                scan_idx_next   = '0;
                best_found_next = 1'b0;
            end
            ST_NEAREST:
            begin
                if (slot_rd.valid && (!best_found_reg || (cmp_dist < best_d_reg)))
                begin
                    best_found_next = 1'b1;
                    best_d_next     = cmp_dist;
                    best_seq_next   = slot_rd.seq;
                end
                scan_idx_next = scan_idx_inc;
            end
            ST_SKIP_APPLY:
            begin
                if (best_found_reg)
                begin
                    gap_next      = best_d_reg != '0;
                    exp_next      = best_seq_reg;
                    phase2_next   = 1'b1;
                    scan_idx_next = '0;
                    miss_cnt_next = '0;
                end
            end
            ST_FINISH:
            begin
                out_ctl.start = out_count != '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            limit_reg      <= LIMIT_RESET;
            started_reg    <= 1'b0;
            exp_reg        <= '0;
            scan_idx_reg   <= '0;
            miss_cnt_reg   <= '0;
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            gap_reg        <= 1'b0;
            phase2_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            started_reg    <= started_next;
            exp_reg        <= exp_next;
            scan_idx_reg   <= scan_idx_next;
            miss_cnt_reg   <= miss_cnt_next;
            dup_reg        <= dup_next;
            free_found_reg <= free_found_next;
            best_found_reg <= best_found_next;
            gap_reg        <= gap_next;
            phase2_reg     <= phase2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg      <= seq_next;
        handle_reg   <= handle_next;
        free_idx_reg <= free_idx_next;
        best_d_reg   <= best_d_next;
        best_seq_reg <= best_seq_next;
    end

    a_no_accept_while_draining: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input accepted while results still draining");

    a_run_ends_on_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("results continue after last transaction of run");

    a_pending_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        (pending_count <= SLOTS_CNT) && (out_count <= SLOTS_CNT))
        else $error("slot or output count beyond capacity");

endmodule

/* sv/rtpsrb_cmp_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP reorder buffer compare unit
// Shared sequence subtractor and equality compare used by every scan.
// ----------------------------------------------------------------------------
module rtpsrb_cmp_unit (
    input  logic                          a_valid,
    input  logic [rtpsrb_pkg::SEQ_W-1:0]  a_seq,
    input  logic [rtpsrb_pkg::SEQ_W-1:0]  base_seq,
    output logic                          match,
    output logic [rtpsrb_pkg::SEQ_W-1:0]  seq_dist
);
    import rtpsrb_pkg::*;

    assign seq_dist = a_seq - base_seq;
    assign match    = a_valid && (a_seq == base_seq);

endmodule

/* sv/rtpsrb_slot_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP reorder buffer slot store
// Pending packet slots with valid bits, one read index and a pending count.
// ----------------------------------------------------------------------------
module rtpsrb_slot_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rtpsrb_pkg::slot_wr_t          wr,
    input  logic [rtpsrb_pkg::IDX_W-1:0]  rd_idx,
    output rtpsrb_pkg::slot_rd_t          rd,
    output logic [rtpsrb_pkg::CNT_W-1:0]  pending_count
);
    import rtpsrb_pkg::*;

    logic [SLOTS-1:0]    valid_reg;
    logic [SLOTS-1:0]    valid_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [SEQ_W-1:0]    seq_reg    [SLOTS];
    logic [HANDLE_W-1:0] handle_reg [SLOTS];

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (wr.insert)
        begin
            valid_next[wr.insert_idx] = 1'b1;
            count_next                = count_reg + CNT_W'(1);
        end
        if (wr.clear)
        begin
            valid_next[wr.clear_idx] = 1'b0;
            count_next               = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.insert)
        begin
            seq_reg[wr.insert_idx]    <= wr.seq;
            handle_reg[wr.insert_idx] <= wr.handle;
        end
    end

    assign rd.valid      = valid_reg[rd_idx];
    assign rd.seq        = seq_reg[rd_idx];
    assign rd.handle     = handle_reg[rd_idx];
    assign pending_count = count_reg;

endmodule

/* sv/rtpsrb_out_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP reorder buffer output queue
// Collects the released packets of one input and streams them out in order.
// ----------------------------------------------------------------------------
module rtpsrb_out_buffer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rtpsrb_pkg::out_ctl_t                ctl,
    input  logic                                m_axis_tready,
    output logic                                m_axis_tvalid,
    output logic [rtpsrb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast,
    output logic [rtpsrb_pkg::CNT_W-1:0]        count,
    output logic                                busy
);
    import rtpsrb_pkg::*;

    logic [HANDLE_W-1:0] handle_reg [SLOTS];
    logic [SEQ_W-1:0]    seq_reg    [SLOTS];
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [IDX_W-1:0]    rd_ptr_reg;
    logic [IDX_W-1:0]    rd_ptr_next;
    logic                draining_reg;
    logic                draining_next;
    logic                gap_reg;
    logic                gap_next;
    logic                last;
    logic                xfer;

    assign last = (CNT_W'(rd_ptr_reg) + CNT_W'(1)) == count_reg;
    assign xfer = draining_reg && m_axis_tready;

    always_comb
    begin
        count_next    = count_reg;
        rd_ptr_next   = rd_ptr_reg;
        draining_next = draining_reg;
        gap_next      = gap_reg;
        if (ctl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (ctl.start)
        begin
            draining_next = 1'b1;
            gap_next      = ctl.gap;
            rd_ptr_next   = '0;
        end
        if (xfer)
        begin
            if (last)
            begin
                draining_next = 1'b0;
                count_next    = '0;
                rd_ptr_next   = '0;
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            rd_ptr_reg   <= '0;
            draining_reg <= 1'b0;
            gap_reg      <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            rd_ptr_reg   <= rd_ptr_next;
            draining_reg <= draining_next;
            gap_reg      <= gap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            handle_reg[count_reg[IDX_W-1:0]] <= ctl.handle;
            seq_reg[count_reg[IDX_W-1:0]]    <= ctl.seq;
        end
    end

    assign m_axis_tvalid = draining_reg;
    assign m_axis_tdata  = {seq_reg[rd_ptr_reg], handle_reg[rd_ptr_reg]};
    assign m_axis_tuser  = gap_reg;
    assign m_axis_tlast  = last;
    assign count         = count_reg;
    assign busy          = draining_reg;

endmodule
